/* src/hpom_pkg.sv */
// Shared types and constants for the hot pixel occupancy masker.
package hpom_pkg;

  localparam int PIXELS = 4096;
  localparam int ADDR_W = $clog2(PIXELS);

  localparam logic [1:0] REG_EVENTS_PER_CYCLE = 2'd0;
  localparam logic [1:0] REG_MAX_RATE_Q16     = 2'd1;
  localparam logic [1:0] REG_TOTAL_CYCLES     = 2'd2;

  localparam logic CMD_HIT          = 1'b0;
  localparam logic CMD_END_OF_EVENT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] pixel_index;
  } item_t;

  typedef struct packed {
    logic        pixel_masked;
    logic        cycle_closed;
    logic [12:0] killed_count;
    logic [15:0] cycle_number;
    logic        finished;
  } result_t;

  typedef struct packed {
    logic        mask;
    logic [15:0] stamp;
    logic [15:0] count;
  } pix_word_t;

endpackage

/* src/hot_pixel_occupancy_masker.sv */
// Hot pixel masker that counts per-pixel event occupancy and masks hot pixels.
//
// Each hit item returns whether its pixel is already masked, and each end-of-event
// item returns one result as well. Per-pixel state (sticky mask, event stamp and
// hit count) lives in one 4096-entry memory with one read and one write port,
// read when an item is accepted and written back when it leaves the stage, with
// forwarding between neighboring hits. A new item can be taken as a hit leaves,
// unless the result side is stalled; an end of event holds off the next item until
// it has left. An end of event that closes a cycle starts a walk over the whole
// memory through that same port pair, one pixel a cycle: its result is given from
// the report state after the walk, and no item is accepted until that state is left.
// After reset a clearing pass writes every entry once, so the block accepts no
// item until the pass is done; configuration writes are taken at any time.
module hot_pixel_occupancy_masker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hpom_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output hpom_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import hpom_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_LIMIT  = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

  pix_word_t mem [PIXELS];
  pix_word_t rd_data;

  logic [2:0]        state;
  logic [15:0]       events_per_cycle;
  logic [15:0]       max_rate_q16;
  logic [15:0]       total_cycles;
  logic [15:0]       event_in_cycle;
  logic [15:0]       cycle_counter;
  logic              s1_valid;
  item_t             s1_item;
  logic [ADDR_W-1:0] walk_addr;
  logic              issue_done;
  logic              wv;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       limit_hi;
  logic [12:0]       killed;

  logic              active;
  logic [15:0]       stamp;
  logic [15:0]       eic_inc;
  logic [15:0]       epc_eff;
  logic [15:0]       close_target;
  logic              closing;
  logic              out_free;
  logic              s1_fire;
  logic              accept_ok;
  logic              accept;
  logic              kill;
  logic              result_load;
  logic [15:0]       cc_inc;
  logic [31:0]       product;
  pix_word_t         hit_word;
  result_t           s1_result;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  pix_word_t         wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  always_comb begin
    active       = cycle_counter <= total_cycles;
    stamp        = event_in_cycle + 16'd1;
    eic_inc      = (event_in_cycle == 16'hFFFF) ? event_in_cycle : event_in_cycle + 16'd1;
    cc_inc       = (cycle_counter == 16'hFFFF) ? cycle_counter : cycle_counter + 16'd1;
    epc_eff      = (events_per_cycle < 16'd2) ? 16'd2 : events_per_cycle;
    close_target = epc_eff - 16'd1;
    closing      = (s1_item.command == CMD_END_OF_EVENT) && active && (eic_inc >= close_target);
    out_free     = !result_valid || !result_stall;
    s1_fire      = s1_valid && out_free && (state == ST_RUN);
    accept_ok    = (state == ST_RUN) &&
                   (!s1_valid || (s1_fire && (s1_item.command == CMD_HIT)));
    item_stall   = !accept_ok;
    accept       = item_valid && accept_ok;
    kill         = !rd_data.mask && (rd_data.count > limit_hi);
    product      = {16'd0, max_rate_q16} * {16'd0, event_in_cycle};
    result_load  = ((state == ST_RUN) && s1_fire && !closing) ||
                   ((state == ST_REPORT) && out_free);

    hit_word       = rd_data;
    hit_word.stamp = stamp;
    if ((rd_data.stamp != stamp) && (rd_data.count != 16'hFFFF)) begin
      hit_word.count = rd_data.count + 16'd1;
    end

    s1_result.pixel_masked = (s1_item.command == CMD_HIT) && active && rd_data.mask;
    s1_result.cycle_closed = 1'b0;
    s1_result.killed_count = '0;
    s1_result.cycle_number = cycle_counter;
    s1_result.finished     = !active;

    we    = 1'b0;
    waddr = walk_addr;
    wdata = '0;
    re    = 1'b0;
    raddr = item.pixel_index[ADDR_W-1:0];
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_RUN: begin
        we    = s1_fire && (s1_item.command == CMD_HIT) && active;
        waddr = s1_item.pixel_index[ADDR_W-1:0];
        wdata = hit_word;
        re    = accept;
      end
      ST_WALK: begin
        we         = wv;
        waddr      = wa;
        wdata.mask = rd_data.mask | kill;
        re         = !issue_done;
        raddr      = walk_addr;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rd_data <= wdata;
      end else begin
        rd_data <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      events_per_cycle <= 16'd100;
      max_rate_q16     <= 16'd13107;
      total_cycles     <= 16'd10;
      event_in_cycle   <= '0;
      cycle_counter    <= '0;
      s1_valid         <= 1'b0;
      result_valid     <= 1'b0;
      walk_addr        <= '0;
      issue_done       <= 1'b0;
      wv               <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EVENTS_PER_CYCLE: events_per_cycle <= cfg_data;
          REG_MAX_RATE_Q16:     max_rate_q16     <= cfg_data;
          REG_TOTAL_CYCLES:     total_cycles     <= cfg_data;
          default: ;
        endcase
      end

      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          walk_addr <= walk_addr + 1'b1;
          if (walk_addr == LAST_ADDR) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (s1_fire) begin
            if (s1_item.command == CMD_END_OF_EVENT && active) begin
              event_in_cycle <= eic_inc;
            end
            if (closing) begin
              state <= ST_LIMIT;
            end
          end
          if (accept) begin
            s1_valid <= 1'b1;
          end else if (s1_fire) begin
            s1_valid <= 1'b0;
          end
        end
        ST_LIMIT: begin
          walk_addr  <= '0;
          issue_done <= 1'b0;
          wv         <= 1'b0;
          state      <= ST_WALK;
        end
        ST_WALK: begin
          wv <= !issue_done;
          if (!issue_done) begin
            if (walk_addr == LAST_ADDR) begin
              issue_done <= 1'b1;
            end else begin
              walk_addr <= walk_addr + 1'b1;
            end
          end
          if (wv && (wa == LAST_ADDR)) begin
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            cycle_counter  <= cc_inc;
            event_in_cycle <= '0;
            state          <= ST_RUN;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    if (state == ST_LIMIT) begin
      limit_hi <= product[31:16];
      killed   <= '0;
    end else if ((state == ST_WALK) && wv && kill && (killed != 13'h1FFF)) begin
      killed <= killed + 13'd1;
    end
    if ((state == ST_WALK) && !issue_done) begin
      wa <= walk_addr;
    end
    if ((state == ST_RUN) && s1_fire && !closing) begin
      result <= s1_result;
    end else if ((state == ST_REPORT) && out_free) begin
      result.pixel_masked <= 1'b0;
      result.cycle_closed <= 1'b1;
      result.killed_count <= killed;
      result.cycle_number <= cc_inc;
      result.finished     <= cc_inc > total_cycles;
    end
  end

  a_no_accept_outside_run: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> item_stall)
    else $error("item accepted while the memory is busy");

  a_eoe_blocks_accept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_item.command == CMD_END_OF_EVENT)) |-> item_stall)
    else $error("item accepted behind a pending end of event");

  a_walk_pipeline_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !s1_valid)
    else $error("pending item during cycle-close walk");

  a_kill_only_on_close: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.cycle_closed) |-> (result.killed_count == 13'd0))
    else $error("killed count reported without a cycle close");

  a_report_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT) |-> ($past(state) == ST_WALK || $past(state) == ST_REPORT))
    else $error("report reached without a walk");

endmodule
